>>> rtl/lower_median_of_two_sets_assert.svh
// Assertion macros shared by the lower median block.
`ifndef LOWER_MEDIAN_OF_TWO_SETS_ASSERT_SVH
`define LOWER_MEDIAN_OF_TWO_SETS_ASSERT_SVH

`ifndef SYNTHESIS
`define LMED_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lower median: same-cycle check failed");
`define LMED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lower median: next-cycle check failed");
`else
`define LMED_ASSERT(lbl, clk, rst_n, ante, cons)
`define LMED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/lmed_pkg.sv
// Shared constants and controller/datapath handshake types for the lower median block.
`timescale 1ns / 1ps
`default_nettype none

package lmed_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  // Flipping the sign bit makes unsigned order match signed order.
  localparam logic [VALUE_W-1:0] SIGN_BIAS = {1'b1, {(VALUE_W - 1){1'b0}}};

  typedef struct packed {
    logic store;
    logic sel_start;
    logic cand_load;
    logic scan_step;
    logic next_cand;
    logic out_load;
  } lmed_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic hit;
  } lmed_stat_t;

endpackage

`default_nettype wire

>>> rtl/lmed_ifs.sv
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface lmed_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lmed_pkg::VALUE_W-1:0]  value;
  logic                                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface lmed_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lmed_pkg::VALUE_W-1:0]  median;
  logic        [lmed_pkg::COUNT_W-1:0]  count_kept;
  logic                                 overflowed;

  modport source (output valid, output median, output count_kept, output overflowed,
                  input ready);
  modport sink   (input valid, input median, input count_kept, input overflowed,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/lmed_dp.sv
// Datapath: value store, fill count, rank counting scan and result register.
`timescale 1ns / 1ps
`default_nettype none

`include "lower_median_of_two_sets_assert.svh"

module lmed_dp #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire lmed_pkg::lmed_cmd_t                cmd,
  output      lmed_pkg::lmed_stat_t               stat,
  input  wire logic [lmed_pkg::VALUE_W-1:0]       in_value,
  output      logic signed [lmed_pkg::VALUE_W-1:0] median,
  output      logic [lmed_pkg::COUNT_W-1:0]       count_kept,
  output      logic                               overflowed
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

  logic [lmed_pkg::VALUE_W-1:0] mem [MAX_ITEMS];

  logic [CW-1:0]                fill_count_r;
  logic                         overflow_r;
  logic [AW-1:0]                cand_idx_r;
  logic [AW-1:0]                scan_idx_r;
  logic [lmed_pkg::VALUE_W-1:0] cand_q_r;
  logic [lmed_pkg::VALUE_W-1:0] scan_q_r;
  logic                         cmp_vld_r;
  logic [CW-1:0]                below_r;
  logic [CW-1:0]                same_r;
  logic [lmed_pkg::VALUE_W-1:0] median_r;
  logic [lmed_pkg::COUNT_W-1:0] count_r;
  logic                         ovf_out_r;

  logic                         full;
  logic [CW-1:0]                rank;
  logic [CW:0]                  span;

  assign full = (fill_count_r == CAP);
  assign rank = (fill_count_r - 1'b1) >> 1;
  assign span = {1'b0, below_r} + {1'b0, same_r};

  assign stat.scan_last = (CW'(scan_idx_r) == (fill_count_r - 1'b1));
  assign stat.hit       = (below_r <= rank) && ({1'b0, rank} < span);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      overflow_r   <= 1'b0;
    end else if (cmd.out_load) begin
      fill_count_r <= '0;
      overflow_r   <= 1'b0;
    end else if (cmd.store) begin
      if (full) begin
        overflow_r <= 1'b1;
      end else begin
        fill_count_r <= fill_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      mem[fill_count_r[AW-1:0]] <= in_value ^ lmed_pkg::SIGN_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_load) begin
      cand_q_r <= mem[cand_idx_r];
    end
    if (cmd.scan_step) begin
      scan_q_r <= mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_start) begin
      cand_idx_r <= '0;
    end else if (cmd.next_cand) begin
      cand_idx_r <= cand_idx_r + 1'b1;
    end
    if (cmd.cand_load) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_step;
    end
  end

  // Read data arrives in the cycle after its scan address, so counting follows cmp_vld_r.
  always_ff @(posedge clk) begin
    if (cmd.cand_load) begin
      below_r <= '0;
      same_r  <= '0;
    end else if (cmp_vld_r) begin
      if (scan_q_r < cand_q_r) begin
        below_r <= below_r + 1'b1;
      end else if (scan_q_r == cand_q_r) begin
        same_r <= same_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      median_r  <= cand_q_r ^ lmed_pkg::SIGN_BIAS;
      count_r   <= lmed_pkg::COUNT_W'(fill_count_r);
      ovf_out_r <= overflow_r;
    end
  end

  assign median     = $signed(median_r);
  assign count_kept = count_r;
  assign overflowed = ovf_out_r;

  `LMED_ASSERT(a_fill_bound, clk, rst_n, 1'b1, fill_count_r <= CAP)
  `LMED_ASSERT_NEXT(a_out_clears_set, clk, rst_n, cmd.out_load, (fill_count_r == '0) && !overflow_r)
  `LMED_ASSERT(a_cand_in_range, clk, rst_n, cmd.next_cand, CW'(cand_idx_r) < (fill_count_r - 1'b1))

endmodule

`default_nettype wire

>>> rtl/lmed_ctrl.sv
// Controller: sequences loading, the candidate scans and the hand-off of the result.
`timescale 1ns / 1ps
`default_nettype none

`include "lower_median_of_two_sets_assert.svh"

module lmed_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_last,
  output      logic                  in_ready,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire lmed_pkg::lmed_stat_t  stat,
  output      lmed_pkg::lmed_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND,
    ST_SCAN,
    ST_DRAIN,
    ST_CHECK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            cmd.sel_start = 1'b1;
            state_nxt     = ST_CAND;
          end
        end
      end
      ST_CAND: begin
        cmd.cand_load = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.hit) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.next_cand = 1'b1;
          state_nxt     = ST_CAND;
        end
      end
      ST_DONE: begin
        // The result register is free once its previous beat has gone.
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `LMED_ASSERT(a_no_store_busy, clk, rst_n, state_r != ST_IDLE, !cmd.store)
  `LMED_ASSERT(a_cmd_exclusive, clk, rst_n, 1'b1, $onehot0({cmd.cand_load, cmd.scan_step, cmd.next_cand, cmd.out_load, cmd.store}))

endmodule

`default_nettype wire

>>> rtl/lower_median_of_two_sets.sv
// Top level of the lower median block: collects a set of values and returns its lower median.
// Items without the last mark are taken one per cycle while idle; the store has room for MAX_ITEMS values.
// After the last beat each candidate in turn is loaded, scanned over the N kept values on the two-port store
// and checked; input is held off until the result is loaded.
// Synchronous active-low reset empties the set and drops any undelivered result.
`timescale 1ns / 1ps
`default_nettype none

module lower_median_of_two_sets #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lmed_in_if.sink     in_ch,
  lmed_out_if.source  out_ch
);

  lmed_pkg::lmed_cmd_t  cmd;
  lmed_pkg::lmed_stat_t stat;

  lmed_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lmed_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_value   (in_ch.value),
    .median     (out_ch.median),
    .count_kept (out_ch.count_kept),
    .overflowed (out_ch.overflowed)
  );

endmodule

`default_nettype wire
